// ===== design/hsvl_pkg.sv =====
// shared types, constants and the led bit encoder for the hsv to led spi block
// no dependencies
`default_nettype none

package hsvl_pkg;

  localparam int unsigned ColourW = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned ChanW   = 2;

  // one nibble per colour bit on the led line
  localparam logic [3:0] NibOne  = 4'hE;
  localparam logic [3:0] NibZero = 4'h8;

  // hue wheel sections, anything above section one folds into section two
  localparam logic [1:0] SecRedGreen  = 2'd0;
  localparam logic [1:0] SecGreenBlue = 2'd1;

  typedef logic [ChanW-1:0] channel_t;

  localparam channel_t ChGreen = 2'd0;
  localparam channel_t ChRed   = 2'd1;
  localparam channel_t ChBlue  = 2'd2;

  typedef struct packed {
    logic [ColourW-1:0] green;
    logic [ColourW-1:0] red;
    logic [ColourW-1:0] blue;
  } rgb_t;

  // byte k of the word holds bits 7-2k and 6-2k, high nibble first
  function automatic logic [WordW-1:0] encode_byte(input logic [ColourW-1:0] b);
    logic [WordW-1:0] w;
    w = '0;
    for (int k = 0; k < 4; k++) begin
      w[8*k+4 +: 4] = b[7-2*k] ? NibOne : NibZero;
      w[8*k   +: 4] = b[6-2*k] ? NibOne : NibZero;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/hsv_pixel_to_led_spi_words.sv =====
// top level: hsv pixel in, three led spi words out (green, red, blue)
// the first word is valid once the pixel has passed the colour pipeline and been loaded into the serialiser
// pixel rate is set by the single-word output port, which sends each pixel's three words one at a time
// reset: synchronous active-low rst_n clears all stage valid bits and the word counter
// depends on hsvl_pkg, hsvl_colour_pipe, hsvl_word_serialiser
`default_nettype none

module hsv_pixel_to_led_spi_words (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // pixel input
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [7:0]                 in_hue,
  input  wire logic [7:0]                 in_saturation,
  input  wire logic [7:0]                 in_brightness,
  // spi word output
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [hsvl_pkg::WordW-1:0]      out_spi_word,
  output hsvl_pkg::channel_t              out_channel,
  output logic                            out_last
);
  import hsvl_pkg::*;

  // rgb pixel between the colour pipeline and the serialiser
  logic pix_valid;
  logic pix_ready;
  rgb_t pix_rgb;

  // stage 1 works out the floor, stage 2 the two ramp products,
  // stage 3 adds the floor and picks the wheel section;
  // each stage moves on its own so bubbles close up under a stall
  hsvl_colour_pipe u_colour_pipe (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .pix_valid     (pix_valid),
    .pix_ready     (pix_ready),
    .pix_rgb       (pix_rgb)
  );

  // encodes all three bytes on load and shifts one word out per handshake;
  // a new pixel loads in the same cycle the blue word leaves
  hsvl_word_serialiser u_word_serialiser (
    .clk          (clk),
    .rst_n        (rst_n),
    .pix_valid    (pix_valid),
    .pix_ready    (pix_ready),
    .pix_rgb      (pix_rgb),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_spi_word (out_spi_word),
    .out_channel  (out_channel),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire

// ===== design/hsvl_colour_pipe.sv =====
// three stage hsv to rgb pipeline: floor, ramp products, section select
// depends on hsvl_pkg
`default_nettype none

module hsvl_colour_pipe (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_hue,
  input  wire logic [7:0]            in_saturation,
  input  wire logic [7:0]            in_brightness,
  output logic                       pix_valid,
  input  wire logic                  pix_ready,
  output hsvl_pkg::rgb_t             pix_rgb
);
  import hsvl_pkg::*;

  // stage valid bits
  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic ld1, ld2, ld3;

  // stage 1 payload
  logic [7:0] floor1_r, val1_r, hue1_r;
  logic [15:0] floor_prod;
  // stage 2 payload
  logic [7:0] amp;
  logic [5:0] offset, offset_inv;
  logic [13:0] up_prod, down_prod;
  logic [7:0] up2_r, down2_r, floor2_r;
  logic [1:0] sec2_r;
  // stage 3 payload
  logic [7:0] up_sum, down_sum;
  rgb_t rgb_nxt, rgb3_r;

  assign ld3 = !v3_r || pix_ready;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;
  assign in_ready = ld1;

  assign v1_nxt = ld1 ? in_valid : v1_r;
  assign v2_nxt = ld2 ? v1_r : v2_r;
  assign v3_nxt = ld3 ? v2_r : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // floor = brightness * (255 - saturation) / 256
  assign floor_prod = 16'(in_brightness) * 16'(8'd255 - in_saturation);

  always_ff @(posedge clk) begin
    if (ld1) begin
      floor1_r <= floor_prod[15:8];
      val1_r   <= in_brightness;
      hue1_r   <= in_hue;
    end
  end

  // ramp products over the amplitude
  assign amp        = val1_r - floor1_r;
  assign offset     = hue1_r[5:0];
  assign offset_inv = 6'd63 - offset;
  assign up_prod    = 14'(offset) * 14'(amp);
  assign down_prod  = 14'(offset_inv) * 14'(amp);

  always_ff @(posedge clk) begin
    if (ld2) begin
      up2_r    <= up_prod[13:6];
      down2_r  <= down_prod[13:6];
      floor2_r <= floor1_r;
      sec2_r   <= hue1_r[7:6];
    end
  end

  assign up_sum   = up2_r + floor2_r;
  assign down_sum = down2_r + floor2_r;

  always_comb begin
    case (sec2_r)
      SecRedGreen: begin
        rgb_nxt.red   = down_sum;
        rgb_nxt.green = up_sum;
        rgb_nxt.blue  = floor2_r;
      end
      SecGreenBlue: begin
        rgb_nxt.red   = floor2_r;
        rgb_nxt.green = down_sum;
        rgb_nxt.blue  = up_sum;
      end
      default: begin
        rgb_nxt.red   = up_sum;
        rgb_nxt.green = floor2_r;
        rgb_nxt.blue  = down_sum;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      rgb3_r <= rgb_nxt;
    end
  end

  assign pix_valid = v3_r;
  assign pix_rgb   = rgb3_r;

endmodule

`default_nettype wire

// ===== design/hsvl_word_serialiser.sv =====
// encodes one rgb pixel into three led spi words and sends them green, red, blue
// depends on hsvl_pkg
`default_nettype none

module hsvl_word_serialiser (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       pix_valid,
  output logic                            pix_ready,
  input  wire hsvl_pkg::rgb_t             pix_rgb,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [hsvl_pkg::WordW-1:0]      out_spi_word,
  output hsvl_pkg::channel_t              out_channel,
  output logic                            out_last
);
  import hsvl_pkg::*;

  logic             busy_r, busy_nxt;
  channel_t         chan_r, chan_nxt;
  logic [WordW-1:0] word0_r, word1_r, word2_r;
  logic             take, load, on_last;

  assign on_last   = (chan_r == ChBlue);
  assign take      = busy_r && out_ready;
  assign pix_ready = !busy_r || (out_ready && on_last);
  assign load      = pix_valid && pix_ready;

  always_comb begin
    busy_nxt = busy_r;
    chan_nxt = chan_r;
    if (load) begin
      busy_nxt = 1'b1;
      chan_nxt = ChGreen;
    end else if (take) begin
      if (on_last) begin
        busy_nxt = 1'b0;
      end else begin
        chan_nxt = chan_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      chan_r <= ChGreen;
    end else begin
      busy_r <= busy_nxt;
      chan_r <= chan_nxt;
    end
  end

  // word shift line, head word drives the port
  always_ff @(posedge clk) begin
    if (load) begin
      word0_r <= encode_byte(pix_rgb.green);
      word1_r <= encode_byte(pix_rgb.red);
      word2_r <= encode_byte(pix_rgb.blue);
    end else if (take) begin
      word0_r <= word1_r;
      word1_r <= word2_r;
    end
  end

  assign out_valid    = busy_r;
  assign out_spi_word = word0_r;
  assign out_channel  = chan_r;
  assign out_last     = on_last;

endmodule

`default_nettype wire

// ===== design/hsvl_checker.sv =====
// port-level checker for the hsv to led spi block, bound to the top level
// depends on hsvl_pkg
`default_nettype none

module hsvl_checker (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [31:0]           out_spi_word,
  input wire hsvl_pkg::channel_t    out_channel,
  input wire logic                  out_last
);
  import hsvl_pkg::*;

  // nothing comes out straight after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("word valid after reset");

  // last flags the blue word and only that one
  a_last_blue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_channel == ChBlue)))
    else $error("last flag out of step with channel");

  // green is followed by red, red by blue, with no gap
  a_green_red: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_channel == ChGreen) |=>
      (out_valid && out_channel == ChRed))
    else $error("red word missing after green");

  a_red_blue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_channel == ChRed) |=>
      (out_valid && out_channel == ChBlue))
    else $error("blue word missing after red");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_spi_word) && $stable(out_channel)))
    else $error("stalled word changed");

endmodule

bind hsv_pixel_to_led_spi_words hsvl_checker u_hsvl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_spi_word (out_spi_word),
  .out_channel  (out_channel),
  .out_last     (out_last)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for hsv_pixel_to_led_spi_words: random and directed pixels,
// expected led spi words worked out in the bench and compared word by word
// depends on hsvl_pkg and the hsv_pixel_to_led_spi_words rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hsvl_pkg::*;

  // one expected output word
  typedef struct packed {
    logic [WordW-1:0] spi_word;
    channel_t         channel;
    logic             last;
  } led_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // pixel side, all known from time zero
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_hue = 8'h00;
  logic [7:0] in_saturation = 8'h00;
  logic [7:0] in_brightness = 8'h00;

  // word side
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [WordW-1:0] out_spi_word;
  channel_t         out_channel;
  logic             out_last;

  // words still owed by the block, oldest first
  led_word_t led_words[$];
  int        mismatches = 0;
  // when set, neither side idles
  bit        no_gaps = 1'b0;
  int        ready_hold = 0;

  hsv_pixel_to_led_spi_words DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_brightness(in_brightness),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_spi_word (out_spi_word),
    .out_channel  (out_channel),
    .out_last     (out_last)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // expected words
  // ---------------------------------------------------------------------------

  // each colour bit becomes one nibble, bit 7 first; nibble pairs are laid out
  // from the least significant byte upwards, so build big-endian then swap bytes
  function automatic logic [WordW-1:0] led_code(input logic [7:0] colour);
    logic [WordW-1:0] msb_first;
    msb_first = '0;
    for (int i = 7; i >= 0; i--) begin
      msb_first = {msb_first[WordW-5:0], (colour[i] ? NibOne : NibZero)};
    end
    return {msb_first[7:0], msb_first[15:8], msb_first[23:16], msb_first[31:24]};
  endfunction

  // three-section hue wheel, then queue green, red and blue words
  function automatic void predict_pixel(input logic [7:0] hue, input logic [7:0] sat,
                                        input logic [7:0] bri);
    int unsigned floor_v;
    int unsigned amp;
    int unsigned offset;
    int unsigned up;
    int unsigned down;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    floor_v = (bri * (255 - sat)) / 256;
    amp     = bri - floor_v;
    offset  = {26'd0, hue[5:0]};
    up      = (offset * amp) / 64 + floor_v;
    down    = ((63 - offset) * amp) / 64 + floor_v;
    case (hue[7:6])
      SecRedGreen: begin
        red = down[7:0]; green = up[7:0]; blue = floor_v[7:0];
      end
      SecGreenBlue: begin
        red = floor_v[7:0]; green = down[7:0]; blue = up[7:0];
      end
      // the top quarter of the wheel folds into section two
      default: begin
        red = up[7:0]; green = floor_v[7:0]; blue = down[7:0];
      end
    endcase
    led_words.push_back('{led_code(green), ChGreen, 1'b0});
    led_words.push_back('{led_code(red),   ChRed,   1'b0});
    led_words.push_back('{led_code(blue),  ChBlue,  1'b1});
  endfunction

  // ---------------------------------------------------------------------------
  // idling
  // ---------------------------------------------------------------------------

  // mostly none or short, now and then a long one
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver: alternates ready bursts and stalls of random length
  always @(posedge clk) begin
    if (no_gaps) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready) begin
      out_ready  <= 1'b0;
      ready_hold <= idle_len();
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 10);
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // sampled at the falling edge, where everything is settled; a word seen
  // here with valid and ready high is taken at the next rising edge
  always @(negedge clk) begin : word_checker
    led_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (led_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h channel %0d last %0b",
                                  out_spi_word, out_channel, out_last));
      end else begin
        want = led_words.pop_front();
        if (out_spi_word !== want.spi_word)
          report_mismatch($sformatf("spi_word %h, expected %h", out_spi_word, want.spi_word));
        if (out_channel !== want.channel)
          report_mismatch($sformatf("channel %0d, expected %0d", out_channel, want.channel));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_last, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers, all entered and left at a rising edge
  // ---------------------------------------------------------------------------

  task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                            input logic [7:0] bri);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat;
    in_brightness <= bri;
    // ready seen at the falling edge means the pixel goes in at the next rising one
    do @(negedge clk); while (!in_ready);
    predict_pixel(hue, sat, bri);
    @(posedge clk);
  endtask

  // hold the sender until every owed word has come out
  task automatic wait_all_words();
    in_valid <= 1'b0;
    do @(posedge clk); while (led_words.size() != 0);
  endtask

  // random byte leaning on the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // random hue, now and then right on a section boundary
  function automatic logic [7:0] pick_hue();
    logic [1:0] sec;
    sec = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0: return {sec, 6'h00};
      1: return {sec, 6'h3F};
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // both ends of every wheel section, including the folded top quarter
  task automatic test_wheel_sections();
    logic [7:0] edges[8] = '{8'd0, 8'd63, 8'd64, 8'd127, 8'd128, 8'd191, 8'd192, 8'd255};
    foreach (edges[i]) send_pixel(edges[i], 8'hFF, 8'hFF);
    // mid-section hues with partial saturation
    send_pixel(8'd32,  8'd128, 8'd200);
    send_pixel(8'd96,  8'd128, 8'd200);
    send_pixel(8'd160, 8'd128, 8'd200);
    send_pixel(8'd224, 8'd128, 8'd200);
  endtask

  // black, white, grey, zero brightness and alternating bit patterns
  task automatic test_extremes();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd100, 8'h00, 8'hFF);
    send_pixel(8'd10, 8'hFF, 8'h00);
    send_pixel(8'h55, 8'hAA, 8'h5A);
    send_pixel(8'hAA, 8'h55, 8'hA5);
    send_pixel(8'd200, 8'd1, 8'd1);
    send_pixel(8'd40, 8'd254, 8'hFF);
  endtask

  // full rate on both sides, no idling at all
  task automatic test_back_to_back();
    no_gaps = 1'b1;
    repeat (60) send_pixel(pick_hue(), pick_byte(), pick_byte());
    wait_all_words();
    no_gaps = 1'b0;
  endtask

  // random pixels with random idling, draining the block now and then
  task automatic test_random_pixels();
    for (int i = 0; i < 370; i++) begin
      send_pixel(pick_hue(), pick_byte(), pick_byte());
      if (i % 125 == 124) wait_all_words();
    end
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_wheel_sections();
    test_extremes();
    test_back_to_back();
    test_random_pixels();

    // drain, then give stray words a chance to show up with the receiver open
    wait_all_words();
    no_gaps = 1'b1;
    repeat (12) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2ms;
    $display("timeout with %0d words outstanding", led_words.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
